[sv/aepc_pkg.sv]
// Shared constants and a helper function for the archive entry path checker.
// No dependencies; used by aepc_path_state and archive_entry_path_checker_core.
`default_nettype none

package aepc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 10;
    localparam int unsigned COUNT_W = LEN_W + 1;
    localparam int unsigned COMP_W  = 2;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd255;

    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;

    localparam logic [COMP_W-1:0] COMP_SAT = 2'd3;

    // Characters that are never allowed anywhere in a name.
    function automatic logic is_bad_char(input logic [BYTE_W-1:0] ch);
        return (ch < CH_SPACE) || (ch == CH_DEL) || (ch == CH_BSLASH) || (ch == CH_COLON);
    endfunction

endpackage

`default_nettype wire

[sv/aepc_path_state.sv]
// Per-name scan state: length count, current component tracking and reject flag.
// Depends on aepc_pkg.
`default_nettype none

module aepc_path_state (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [aepc_pkg::BYTE_W-1:0] i_byte,
    input  wire logic [aepc_pkg::LEN_W-1:0]  i_max_len,
    output logic                             o_name_ok
);
    import aepc_pkg::*;

    logic [COUNT_W-1:0] r_chars;
    logic [COUNT_W-1:0] n_chars;
    logic [COMP_W-1:0]  r_comp_len;
    logic [COMP_W-1:0]  n_comp_len;
    logic               r_all_dots;
    logic               n_all_dots;
    logic               r_rej;
    logic               n_rej;

    logic               dot_name;
    logic               too_long;
    logic [COUNT_W-1:0] max_ext;

    assign max_ext  = {1'b0, i_max_len};
    assign too_long = r_chars > max_ext;
    assign dot_name = r_all_dots && ((r_comp_len == 2'd1) || (r_comp_len == 2'd2));

    // Verdict for a terminator arriving now.
    assign o_name_ok = !r_rej && (r_chars != '0) && !too_long && !dot_name;

    always_comb begin
        n_chars    = r_chars;
        n_comp_len = r_comp_len;
        n_all_dots = r_all_dots;
        n_rej      = r_rej;
        if (i_step) begin
            if (i_byte == CH_NUL) begin
                n_chars    = '0;
                n_comp_len = '0;
                n_all_dots = 1'b1;
                n_rej      = 1'b0;
            end else begin
                if (is_bad_char(i_byte)) begin
                    n_rej = 1'b1;
                end
                if (i_byte == CH_SLASH) begin
                    // An empty component here also catches a leading slash.
                    if ((r_comp_len == '0) || dot_name) begin
                        n_rej = 1'b1;
                    end
                    n_comp_len = '0;
                    n_all_dots = 1'b1;
                end else begin
                    if (r_comp_len != COMP_SAT) begin
                        n_comp_len = r_comp_len + 1'b1;
                    end
                    if (i_byte != CH_DOT) begin
                        n_all_dots = 1'b0;
                    end
                end
                // The count stops one past the limit.
                if (!too_long) begin
                    n_chars = r_chars + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars    <= '0;
            r_comp_len <= '0;
            r_all_dots <= 1'b1;
            r_rej      <= 1'b0;
        end else begin
            r_chars    <= n_chars;
            r_comp_len <= n_comp_len;
            r_all_dots <= n_all_dots;
            r_rej      <= n_rej;
        end
    end

endmodule

`default_nettype wire

[sv/archive_entry_path_checker_core.sv]
// Top level of the archive entry path checker: input register, scan state, result register.
// Depends on aepc_pkg and aepc_path_state.
//
// Usage: name characters arrive one per item on the input channel (i_valid, o_stall,
// i_name_byte). A zero byte ends the name; for it, one item with o_name_ok appears on
// the output channel (o_valid, i_stall). Other bytes produce no result.
// The longest accepted name is set through i_cfg_we / i_cfg_data, written while idle.
// A terminator moves from the input register to the result register, which drives o_valid.
// Throughput: one byte per cycle while o_stall is low; the per-byte update is
// a few compares and a counter between the input register and the scan state registers.
// When the receiver stalls, the verdict holds in the result register; non-terminator
// bytes keep flowing, and a second terminator waits in the input register, which then
// raises o_stall until the result is taken.
// Reset clears all name state and sets the limit to 255 characters.
`default_nettype none

module archive_entry_path_checker_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [aepc_pkg::BYTE_W-1:0] i_name_byte,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_name_ok,
    input  wire logic                        i_cfg_we,
    input  wire logic [aepc_pkg::LEN_W-1:0]  i_cfg_data
);
    import aepc_pkg::*;

    logic [LEN_W-1:0]  r_max_len;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic              r_name_ok;

    logic              out_free;
    logic              is_term;
    logic              advance;
    logic              in_take;
    logic              verdict;

    assign out_free = !r_out_valid || !i_stall;
    assign is_term  = r_in_byte == CH_NUL;
    assign advance  = r_in_valid && (!is_term || out_free);
    assign in_take  = i_valid && !o_stall;
    assign o_stall  = r_in_valid && !advance;
    assign o_valid  = r_out_valid;
    assign o_name_ok = r_name_ok;

    aepc_path_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_name_ok (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && is_term) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_name_byte;
        end
        if (advance && is_term) begin
            r_name_ok <= verdict;
        end
    end

    // A waiting terminator must stall the input while the result register is blocked.
    a_term_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && is_term && r_out_valid && i_stall) |-> o_stall)
        else $error("terminator passed a blocked result register");

    // A terminator leaving the input register always produces a result.
    a_term_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_term) |=> r_out_valid)
        else $error("terminator produced no result");

    // An empty input register never stalls the sender.
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("stall raised with empty input register");

    // Non-terminator bytes never wait on the output side.
    a_byte_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !is_term) |-> advance)
        else $error("non-terminator byte held up");

endmodule

`default_nettype wire

[bench/tb_archive_entry_path_checker_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for archive_entry_path_checker_core: directed and random names,
// a local predictor of the verdicts, and an in-order check of every result item.
// Depends on aepc_pkg and the RTL of the checker.

module tb_archive_entry_path_checker_core;

    import aepc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_PERCENT = 14;
    localparam logic [BYTE_W-1:0] CH_LETTER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_TOP = 8'hFF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [BYTE_W-1:0] i_name_byte = '0;
    logic i_stall = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [LEN_W-1:0] i_cfg_data = '0;
    logic o_stall;
    logic o_valid;
    logic o_name_ok;

    // Shadow of the scan state and the length limit.
    logic [COUNT_W-1:0] seen_chars = '0;
    logic [COMP_W-1:0] comp_len = '0;
    logic comp_all_dots = 1'b1;
    logic name_rejected = 1'b0;
    logic [LEN_W-1:0] limit_shadow = MAX_LEN_RESET;

    bit expected_name_ok[$];
    logic [BYTE_W-1:0] name_buf[$];
    int fail_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    bit idle_on = 1'b1;

    archive_entry_path_checker_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_name_byte(i_name_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_name_ok(o_name_ok),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Result checker: every accepted verdict is matched against the oldest prediction.
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_name_ok.size() == 0) begin
                $error("name_ok: no verdict expected, actual %0b", o_name_ok);
                fail_count++;
            end else begin
                want = expected_name_ok.pop_front();
                if (o_name_ok !== want) begin
                    $error("name_ok mismatch: expected %0b, actual %0b", want, o_name_ok);
                    fail_count++;
                end
            end
        end
    end

    task automatic predict_path_byte(input logic [BYTE_W-1:0] ch);
        logic dot_name;
        logic ok;
        dot_name = comp_all_dots && (comp_len == 2'd1 || comp_len == 2'd2);
        if (ch == CH_NUL) begin
            ok = !name_rejected && (seen_chars != '0) &&
                 (seen_chars <= {1'b0, limit_shadow}) && !dot_name;
            expected_name_ok.push_back(ok);
            seen_chars = '0;
            comp_len = '0;
            comp_all_dots = 1'b1;
            name_rejected = 1'b0;
        end else begin
            if (ch < CH_SPACE || ch == CH_DEL || ch == CH_BSLASH || ch == CH_COLON)
                name_rejected = 1'b1;
            if (ch == CH_SLASH) begin
                // A slash closing an empty component or one of only one or two dots is never allowed.
                if (comp_len == '0 || dot_name)
                    name_rejected = 1'b1;
                comp_len = '0;
                comp_all_dots = 1'b1;
            end else begin
                if (comp_len != COMP_SAT)
                    comp_len = comp_len + 1'b1;
                if (ch != CH_DOT)
                    comp_all_dots = 1'b0;
            end
            if (seen_chars <= {1'b0, limit_shadow})
                seen_chars = seen_chars + 1'b1;
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] ch);
        @(negedge i_clk);
        if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_name_byte <= ch;
        do @(posedge i_clk); while (o_stall);
        predict_path_byte(ch);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
        send_byte(CH_NUL);
    endtask

    task automatic send_name_buf();
        foreach (name_buf[i])
            send_byte(name_buf[i]);
        send_byte(CH_NUL);
    endtask

    // Holds the sender until every predicted verdict has come back and the block is quiet.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_name_ok.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        limit_shadow = value;
    endtask

    function automatic logic [BYTE_W-1:0] plain_char();
        logic [BYTE_W-1:0] ch;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: ch = CH_LETTER_A + BYTE_W'($urandom_range(25));
            6: ch = CH_DOT;
            7: ch = BYTE_W'($urandom_range(8'h80, 8'hFF));
            8: begin
                do ch = BYTE_W'($urandom_range(CH_SPACE, CH_TILDE));
                while (ch == CH_SLASH || ch == CH_BSLASH || ch == CH_COLON);
            end
            default: ch = CH_DASH;
        endcase
        return ch;
    endfunction

    function automatic logic [BYTE_W-1:0] noise_char();
        logic [BYTE_W-1:0] ch;
        case ($urandom_range(5))
            0: ch = CH_SLASH;
            1: ch = CH_DOT;
            2: begin
                case ($urandom_range(3))
                    0: ch = BYTE_W'($urandom_range(1, 8'h1F));
                    1: ch = CH_DEL;
                    2: ch = CH_BSLASH;
                    default: ch = CH_COLON;
                endcase
            end
            default: ch = BYTE_W'($urandom_range(1, 8'hFF));
        endcase
        return ch;
    endfunction

    // Most names are well formed with random content; the rest are random noise that may hold defects.
    task automatic build_random_name();
        int ncomp;
        int clen;
        bit dots_only;
        logic [BYTE_W-1:0] ch;
        name_buf.delete();
        if ($urandom_range(99) < 70) begin
            ncomp = $urandom_range(1, 4);
            for (int c = 0; c < ncomp; c++) begin
                if (c != 0)
                    name_buf.push_back(CH_SLASH);
                clen = $urandom_range(1, 5);
                dots_only = 1'b1;
                for (int j = 0; j < clen; j++) begin
                    ch = ($urandom_range(4) == 0) ? CH_DOT : plain_char();
                    if (ch != CH_DOT)
                        dots_only = 1'b0;
                    name_buf.push_back(ch);
                end
                if (dots_only && clen <= 2)
                    name_buf.push_back(CH_LETTER_A);
            end
            if ($urandom_range(4) == 0)
                name_buf.push_back(CH_SLASH);
        end else begin
            clen = $urandom_range(0, 10);
            for (int j = 0; j < clen; j++)
                name_buf.push_back(noise_char());
        end
    endtask

    task automatic build_long_name(input int len);
        name_buf.delete();
        for (int i = 0; i < len; i++) begin
            if (i % 9 == 8 && i != len - 1)
                name_buf.push_back(CH_SLASH);
            else
                name_buf.push_back(CH_LETTER_A + BYTE_W'(i % 26));
        end
    endtask

    task automatic test_dot_and_slash_names();
        send_text("");
        send_text("/");
        send_text("a/");
        send_text("a//b");
        send_text(".");
        send_text("..");
        send_text("...");
        send_text("./a");
    endtask

    task automatic test_forbidden_chars();
        send_byte(8'h01);
        send_byte(CH_NUL);
        send_byte(8'h1F);
        send_byte(CH_NUL);
        send_byte(CH_DEL);
        send_byte(CH_NUL);
        send_text("\\");
        send_text(":");
        send_byte(CH_TOP);
        send_byte(CH_NUL);
        send_text(" ");
    endtask

    task automatic test_length_boundaries();
        write_limit(10'd1);
        send_text("a");
        send_text("ab");
        write_limit(10'd0);
        send_text("a");
        write_limit(10'd3);
        send_text("abc");
        send_text("a/bc");
    endtask

    // The limit is lowered while a name is half scanned; the count already lies past it.
    task automatic test_limit_change_mid_name();
        write_limit(10'd3);
        send_byte(CH_LETTER_A);
        send_byte(CH_LETTER_A + 8'd1);
        write_limit(10'd1);
        send_byte(CH_LETTER_A + 8'd2);
        send_byte(CH_NUL);
    endtask

    // At the limit left by reset, a name of 256 characters is one too long.
    task automatic test_long_names();
        build_long_name(256);
        send_name_buf();
    endtask

    task automatic test_random_names(input logic [LEN_W-1:0] limit, input int item_count,
                                     input bit with_idle);
        int stop_at;
        write_limit(limit);
        idle_on = with_idle;
        stop_at = items_sent + item_count;
        while (items_sent < stop_at) begin
            build_random_name();
            send_name_buf();
            if ($urandom_range(11) == 0)
                drain_results();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_dot_and_slash_names();
        test_forbidden_chars();
        test_long_names();
        test_length_boundaries();
        test_limit_change_mid_name();
        test_random_names(10'd7, 25, 1'b1);
        test_random_names(10'd12, 35, 1'b0);
        test_random_names(10'd255, 30, 1'b1);
        test_random_names(10'd1, 15, 1'b1);
        test_random_names(10'd4, 20, 1'b1);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (expected_name_ok.size() != 0) begin
            $error("name_ok: %0d verdicts never arrived", expected_name_ok.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
sv/aepc_pkg.sv
sv/aepc_path_state.sv
sv/archive_entry_path_checker_core.sv
bench/tb_archive_entry_path_checker_core.sv
